// ===== hdl/efwd_pkg.sv =====
package efwd_pkg;

    // Sizing of the window bank and of the internal time values.
    localparam int MAX_WINDOWS = 8;
    localparam int TIME_WIDTH  = 24;

    localparam int IDX_W   = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
    localparam int TREE_N  = 1 << IDX_W;
    localparam int EXT_W   = (TIME_WIDTH > 20) ? TIME_WIDTH : 20;
    localparam int OUT_W   = (TIME_WIDTH > 24) ? TIME_WIDTH : 24;
    localparam int SUM_W   = ((TIME_WIDTH > 32) ? TIME_WIDTH : 32) + 1;

    // Configuration register indexes.
    localparam logic [3:0] REG_NUM_WINDOWS = 4'd0;
    localparam logic [3:0] REG_MAX_SERVICE = 4'd1;

    localparam logic [3:0] RST_NUM_WINDOWS = 4'd8;
    localparam logic [9:0] RST_MAX_SERVICE = 10'd60;

    typedef logic [TIME_WIDTH-1:0] t_time;
    typedef logic [IDX_W-1:0]      t_idx;
    typedef logic [TIME_WIDTH:0]   t_key;
    typedef logic [15:0]           t_cnt;

    // Saturate an internal time value to the 24-bit output range.
    function automatic logic [23:0] sat24(input t_time v);
        logic [OUT_W-1:0] ext;
        ext = OUT_W'(v);
        if (ext > OUT_W'(24'hFF_FFFF)) begin
            return 24'hFF_FFFF;
        end
        return 24'(ext);
    endfunction

endpackage

// ===== hdl/earliest_free_window_dispatch.sv =====
// Earliest-free-window dispatcher.
// Path: an accepted job beat is held in the input register, and its result beat
// is then held in the result register before it leaves on the result stream.
// Throughput: one job per cycle unless the result stream stalls; the window bank and
// statistics are updated in the same cycle a job moves from input to result register.
// Reset (i_rst_n low, synchronous) clears all finish times, counts and statistics
// and restores num_windows to 8 and max_service to 60.
module earliest_free_window_dispatch (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Job stream. tdata: arrival_time[19:0], service_length[29:20], zero pad [31:30].
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [31:0]  i_s_tdata,
    // Result stream. tdata: window_index[2:0], wait_time[26:3], window_served[42:27],
    // jobs_served[58:43], total_wait[90:59], longest_wait[114:91],
    // latest_finish[138:115], zero pad [143:139].
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [143:0] o_m_tdata,
    // Configuration writes: index 0 is num_windows, index 1 is max_service.
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [3:0]   i_cfg_index,
    input  logic [9:0]   i_cfg_data
);

    // Configuration registers. Writes are always taken.
    logic [3:0] r_num_windows;
    logic [9:0] r_max_service;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_windows <= efwd_pkg::RST_NUM_WINDOWS;
            r_max_service <= efwd_pkg::RST_MAX_SERVICE;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                efwd_pkg::REG_NUM_WINDOWS: r_num_windows <= i_cfg_data[3:0];
                efwd_pkg::REG_MAX_SERVICE: r_max_service <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input register. A job moves on whenever the result register is free or
    // being emptied, so a new beat can be taken in every cycle while the result stream is not stalled.
    logic        r_in_valid;
    logic [19:0] r_arrival;
    logic [9:0]  r_service;
    logic        proc_fire;

    assign proc_fire  = r_in_valid && (!o_m_tvalid || i_m_tready);
    assign o_s_tready = !r_in_valid || proc_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_arrival <= i_s_tdata[19:0];
            r_service <= i_s_tdata[29:20];
        end
    end

    // Window bank and running statistics.
    efwd_pkg::t_time r_finish [efwd_pkg::MAX_WINDOWS];
    efwd_pkg::t_cnt  r_served [efwd_pkg::MAX_WINDOWS];
    efwd_pkg::t_cnt  r_job_count;
    logic [31:0]     r_wait_sum;
    efwd_pkg::t_time r_wait_max;
    efwd_pkg::t_time r_finish_max;

    // Arrival time clipped to the largest representable time, service to the cap.
    efwd_pkg::t_time                 arrival;
    logic [9:0]                      service;
    logic [efwd_pkg::EXT_W-1:0]      arr_ext;
    logic [efwd_pkg::MAX_WINDOWS-1:0] active;
    efwd_pkg::t_time                 eff [efwd_pkg::MAX_WINDOWS];

    always_comb begin
        arr_ext = efwd_pkg::EXT_W'(r_arrival);
        if (arr_ext > efwd_pkg::EXT_W'({efwd_pkg::TIME_WIDTH{1'b1}})) begin
            arrival = '1;
        end else begin
            arrival = efwd_pkg::TIME_WIDTH'(arr_ext);
        end
        service = (r_service > r_max_service) ? r_max_service : r_service;
    end

    // Window 0 is always in use; a count of zero thus acts as one, and counts
    // above the bank size simply enable every window.
    always_comb begin
        for (int h = 0; h < efwd_pkg::MAX_WINDOWS; h++) begin
            active[h] = (h == 0) || ({2'b00, r_num_windows} > 6'(h));
            eff[h]    = (active[h] && (r_finish[h] < arrival)) ? arrival : r_finish[h];
        end
    end

    // Minimum search as a balanced tree. The key carries an idle flag on top so
    // idle windows and padding leaves never win; on equal keys the left
    // (lower-index) side wins.
    efwd_pkg::t_key tree_key [efwd_pkg::IDX_W+1][efwd_pkg::TREE_N];
    efwd_pkg::t_idx tree_idx [efwd_pkg::IDX_W+1][efwd_pkg::TREE_N];
    efwd_pkg::t_idx best;

    always_comb begin
        for (int n = 0; n < efwd_pkg::TREE_N; n++) begin
            if (n < efwd_pkg::MAX_WINDOWS) begin
                tree_key[0][n] = {!active[n], eff[n]};
            end else begin
                tree_key[0][n] = '1;
            end
            tree_idx[0][n] = efwd_pkg::IDX_W'(n);
        end
        for (int l = 1; l <= efwd_pkg::IDX_W; l++) begin
            for (int n = 0; n < efwd_pkg::TREE_N; n++) begin
                if (n < (efwd_pkg::TREE_N >> l)) begin
                    if (tree_key[l-1][2*n+1] < tree_key[l-1][2*n]) begin
                        tree_key[l][n] = tree_key[l-1][2*n+1];
                        tree_idx[l][n] = tree_idx[l-1][2*n+1];
                    end else begin
                        tree_key[l][n] = tree_key[l-1][2*n];
                        tree_idx[l][n] = tree_idx[l-1][2*n];
                    end
                end else begin
                    tree_key[l][n] = '1;
                    tree_idx[l][n] = '0;
                end
            end
        end
        best = tree_idx[efwd_pkg::IDX_W][0];
    end

    // Update values for the chosen window and the statistics.
    efwd_pkg::t_time               start;
    efwd_pkg::t_time               wait_t;
    logic [efwd_pkg::TIME_WIDTH:0] fin_sum;
    efwd_pkg::t_time               fin;
    efwd_pkg::t_cnt                served_nx;
    efwd_pkg::t_cnt                jobs_nx;
    logic [efwd_pkg::SUM_W-1:0]    wsum_ext;
    logic [31:0]                   wsum_nx;
    efwd_pkg::t_time               wmax_nx;
    efwd_pkg::t_time               fmax_nx;

    always_comb begin
        start   = eff[best];
        wait_t  = start - arrival;
        fin_sum = {1'b0, start} + (efwd_pkg::TIME_WIDTH + 1)'(service);
        fin     = fin_sum[efwd_pkg::TIME_WIDTH] ? '1 : fin_sum[efwd_pkg::TIME_WIDTH-1:0];
        served_nx = (r_served[best] == 16'hFFFF) ? r_served[best] : r_served[best] + 16'd1;
        jobs_nx   = (r_job_count == 16'hFFFF) ? r_job_count : r_job_count + 16'd1;
        wsum_ext  = efwd_pkg::SUM_W'(r_wait_sum) + efwd_pkg::SUM_W'(wait_t);
        if (wsum_ext > efwd_pkg::SUM_W'(32'hFFFF_FFFF)) begin
            wsum_nx = 32'hFFFF_FFFF;
        end else begin
            wsum_nx = wsum_ext[31:0];
        end
        wmax_nx = (wait_t > r_wait_max) ? wait_t : r_wait_max;
        fmax_nx = (fin > r_finish_max) ? fin : r_finish_max;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int h = 0; h < efwd_pkg::MAX_WINDOWS; h++) begin
                r_finish[h] <= '0;
                r_served[h] <= '0;
            end
            r_job_count  <= '0;
            r_wait_sum   <= '0;
            r_wait_max   <= '0;
            r_finish_max <= '0;
        end else if (proc_fire) begin
            // Every window in use keeps its raised finish time; the chosen one
            // then takes the new job.
            for (int h = 0; h < efwd_pkg::MAX_WINDOWS; h++) begin
                if (efwd_pkg::IDX_W'(h) == best) begin
                    r_finish[h] <= fin;
                    r_served[h] <= served_nx;
                end else begin
                    r_finish[h] <= eff[h];
                end
            end
            r_job_count  <= jobs_nx;
            r_wait_sum   <= wsum_nx;
            r_wait_max   <= wmax_nx;
            r_finish_max <= fmax_nx;
        end
    end

    // Result register.
    logic         r_out_valid;
    logic [143:0] r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_fire) begin
            r_out_data <= {5'b0,
                           efwd_pkg::sat24(fmax_nx),
                           efwd_pkg::sat24(wmax_nx),
                           wsum_nx,
                           jobs_nx,
                           served_nx,
                           efwd_pkg::sat24(wait_t),
                           3'(best)};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

// ===== hdl/efwd_checker.sv =====
module efwd_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         o_m_tvalid,
    input logic         i_m_tready,
    input logic [143:0] o_m_tdata
);

    // A reset cycle leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result beat pending right after reset");

    // A stalled result beat stays and holds its payload.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result beat changed");

    // The longest wait so far covers the wait of the current job.
    a_max_covers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[114:91] >= o_m_tdata[26:3])
        else $error("longest_wait below wait_time");

    // The total wait covers the wait of the current job.
    a_sum_covers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[90:59] >= 32'(o_m_tdata[26:3]))
        else $error("total_wait below wait_time");

    // Back-to-back result beats carry a rising job count until it saturates.
    a_jobs_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && i_m_tready && (o_m_tdata[58:43] != 16'hFFFF)
        |=> !o_m_tvalid || (o_m_tdata[58:43] > $past(o_m_tdata[58:43])))
        else $error("jobs_served did not advance");

endmodule

bind earliest_free_window_dispatch efwd_checker u_efwd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
